>>> src/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled in reset
`define LKMN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication check
`define LKMN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/lkmn_pkg.sv
package lkmn_pkg;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned Q_FRAC    = 8;
  localparam logic [7:0]  LC_RESET  = 8'd80;

  localparam logic [15:0] CP_POS_3310 = 16'h0CEE;
  localparam logic [15:0] CP_NEG_3310 = 16'hF312;
  localparam logic [15:0] CP_POS_503  = 16'h01F7;
  localparam logic [15:0] CP_NEG_503  = 16'hFE09;

  typedef struct packed {
    logic signed [31:0] power_sample;
    logic signed [15:0] control_program;
    logic [30:0]        search_noise;
    logic               last_gate;
  } in_req_t;

  typedef struct packed {
    logic [31:0] sky_noise;
    logic        used_fallback;
    logic [7:0]  samples_averaged;
  } out_req_t;

  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [VAL_W-1:0] value;
  } ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

endpackage

>>> src/lowest_k_mean_noise_estimator.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  lkmn_pkg::in_req_t
// out      output     out_valid_o / out_stall_i lkmn_pkg::out_req_t
// cfg      input      cfg_valid_i / cfg_ready_o lowest_count (8 bit)
//
// In idle a gate that is not last is taken in; insertion runs through the cell row.
// A last gate takes n shifts to sum the row and a check; unless the check picks
// the fallback, the divider gives one quotient bit per cycle, then the result.
// Fallback cases with nothing to average go straight to the result.
// Reset empties the row at once; a stalled result holds while the next record
// is taken in.
module lowest_k_mean_noise_estimator #(
  parameter int unsigned KEEP_MAX = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lkmn_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lkmn_pkg::out_req_t out_req_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned CW = $clog2(KEEP_MAX + 1);
  localparam int unsigned SW = lkmn_pkg::VAL_W + CW;
  localparam int unsigned VW = lkmn_pkg::VAL_W;

  lkmn_pkg::state_e state_q, state_d;
  lkmn_pkg::ctl_t   ctl;

  logic [7:0]    lc_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] sc_q, sc_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          fb_q, fb_d;
  logic [30:0]   search_q;
  logic          accept, add_en, reserved;
  logic [VW-1:0] mag;
  logic [31:0]   limit, cnt_ext, n_ext;
  logic          out_valid_q, out_load;
  lkmn_pkg::out_req_t out_q, out_d;

  logic [VW-1:0]       vals  [KEEP_MAX];
  logic [KEEP_MAX-1:0] keeps;

  logic          div_start, div_busy, div_done;
  logic [SW-1:0] quo;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != lkmn_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;

  assign mag    = in_req_i.power_sample[31] ? VW'(-in_req_i.power_sample)
                                            : VW'(in_req_i.power_sample);
  assign add_en = accept && (mag != '0);

  assign ctl.ins   = add_en;
  assign ctl.shift = (state_q == lkmn_pkg::ST_SUM);
  assign ctl.value = mag;

  assign reserved = (in_req_i.control_program == lkmn_pkg::CP_POS_3310) ||
                    (in_req_i.control_program == lkmn_pkg::CP_NEG_3310) ||
                    (in_req_i.control_program == lkmn_pkg::CP_POS_503)  ||
                    (in_req_i.control_program == lkmn_pkg::CP_NEG_503);

  for (genvar i = 0; i < KEEP_MAX; i++) begin : g_cell
    logic          pk;
    logic [VW-1:0] pv, nv;
    if (i == 0) begin : g_first
      assign pk = 1'b1;
      assign pv = mag;
    end else begin : g_mid
      assign pk = keeps[i-1];
      assign pv = vals[i-1];
    end
    if (i == KEEP_MAX - 1) begin : g_last
      assign nv = vals[i];
    end else begin : g_next
      assign nv = vals[i+1];
    end
    lkmn_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (CW'(i) < count_q),
      .prev_keep_i (pk),
      .prev_val_i  (pv),
      .next_val_i  (nv),
      .val_o       (vals[i]),
      .keep_o      (keeps[i])
    );
  end

  lkmn_div #(
    .DW (SW),
    .NW (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (n_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    cnt_ext = 32'(count_q) + ((add_en && (count_q < CW'(KEEP_MAX))) ? 32'd1 : 32'd0);
    if (lc_q == 8'd0) begin
      limit = 32'd1;
    end else if (32'(lc_q) > 32'(KEEP_MAX)) begin
      limit = 32'(KEEP_MAX);
    end else begin
      limit = 32'(lc_q);
    end
    n_ext = (cnt_ext < limit) ? cnt_ext : limit;
  end

  assign out_load = (state_q == lkmn_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    count_d   = CW'(cnt_ext);
    n_d       = n_q;
    sc_d      = sc_q;
    sum_d     = sum_q;
    fb_d      = fb_q;
    div_start = 1'b0;
    out_d     = out_q;
    case (state_q)
      lkmn_pkg::ST_IDLE: begin
        if (accept && in_req_i.last_gate) begin
          n_d   = CW'(n_ext);
          sc_d  = '0;
          sum_d = '0;
          if (reserved || n_ext == 32'd0) begin
            fb_d    = 1'b1;
            n_d     = '0;
            count_d = '0;
            state_d = lkmn_pkg::ST_DONE;
          end else begin
            fb_d    = 1'b0;
            state_d = lkmn_pkg::ST_SUM;
          end
        end
      end
      lkmn_pkg::ST_SUM: begin
        sum_d = sum_q + SW'(vals[0]);
        sc_d  = sc_q + 1'b1;
        if (sc_d == n_q) begin
          count_d = '0;
          state_d = lkmn_pkg::ST_CHK;
        end
      end
      lkmn_pkg::ST_CHK: begin
        if (sum_q <= (SW'(n_q) << lkmn_pkg::Q_FRAC)) begin
          fb_d    = 1'b1;
          state_d = lkmn_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = lkmn_pkg::ST_DIV;
        end
      end
      lkmn_pkg::ST_DIV: begin
        if (div_done) begin
          sum_d   = quo;
          state_d = lkmn_pkg::ST_DONE;
        end
      end
      lkmn_pkg::ST_DONE: begin
        if (out_load) begin
          out_d.sky_noise        = fb_q ? {1'b0, search_q} : sum_q[31:0];
          out_d.used_fallback    = fb_q;
          out_d.samples_averaged = 8'(n_q);
          state_d                = lkmn_pkg::ST_IDLE;
        end
      end
      default: state_d = lkmn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkmn_pkg::ST_IDLE;
      count_q     <= '0;
      lc_q        <= lkmn_pkg::LC_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        lc_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    sc_q  <= sc_d;
    sum_q <= sum_d;
    fb_q  <= fb_d;
    out_q <= out_d;
    if (accept && in_req_i.last_gate) begin
      search_q <= in_req_i.search_noise;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `LKMN_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(KEEP_MAX), "kept count overflow")
  `LKMN_ASSERT_IMP(a_div_in_div, clk_i, rst_ni, div_busy, state_q == lkmn_pkg::ST_DIV, "divider busy outside divide")
  `LKMN_ASSERT_IMP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_o), $past(state_q == lkmn_pkg::ST_DONE), "result without finish")

endmodule

>>> src/lkmn_cell.sv
module lkmn_cell (
  input  logic                        clk_i,
  input  lkmn_pkg::ctl_t              ctl_i,
  input  logic                        valid_i,
  input  logic                        prev_keep_i,
  input  logic [lkmn_pkg::VAL_W-1:0]  prev_val_i,
  input  logic [lkmn_pkg::VAL_W-1:0]  next_val_i,
  output logic [lkmn_pkg::VAL_W-1:0]  val_o,
  output logic                        keep_o
);

  logic [lkmn_pkg::VAL_W-1:0] val_q, val_d;

  assign keep_o = valid_i && (val_q <= ctl_i.value);
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins && !keep_o) begin
      val_d = prev_keep_i ? ctl_i.value : prev_val_i;
    end else if (ctl_i.shift) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> src/lkmn_div.sv
module lkmn_div #(
  parameter int unsigned DW = 40,
  parameter int unsigned NW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [NW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [NW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [NW:0]      trial;
  logic             fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? NW'(trial - {1'b0, den_q}) : NW'(trial);
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DW - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_d;

endmodule
